### hdl/mwm_pkg.sv
// Package for the mecanum wheel mixer: widths, constants and lane types.
`timescale 1ns / 1ps
package mwm_pkg;

    // Speed limit applied to every wheel magnitude
    localparam int unsigned SPEED_LIMIT = 100;

    // Field widths
    localparam int unsigned CMD_W   = 8;   // offset-binary command byte
    localparam int unsigned ABS_W   = 8;   // |centered command|, up to 128
    localparam int unsigned SUM_W   = 9;   // |x|+|y|+|w|, up to 384
    localparam int unsigned MIX_W   = 10;  // signed wheel mix, -384..383
    localparam int unsigned MAG_W   = 9;   // |mix|, up to 384
    localparam int unsigned NUM_W   = 16;  // 100*|mix|, up to 38400
    localparam int unsigned SPEED_W = 7;   // wheel magnitude, 0..100

    // One quotient bit per divider stage
    localparam int unsigned DIV_STEPS = SPEED_W;

    // Wheel lanes
    localparam int unsigned N_WHEEL = 4;
    localparam int unsigned WHEEL_LF = 0;
    localparam int unsigned WHEEL_LR = 1;
    localparam int unsigned WHEEL_RF = 2;
    localparam int unsigned WHEEL_RR = 3;

    // Edges from an accepted command to the result strobe being sampled:
    // mix stage, numerator stage, divider stages, output register
    localparam int unsigned LATENCY = 3 + DIV_STEPS;

    // One wheel lane inside the divider
    typedef struct packed {
        logic               neg;   // mix was negative
        logic [NUM_W-1:0]   rem;   // partial remainder
        logic [SPEED_W-1:0] quo;   // quotient bits found so far
    } lane_t;

endpackage

### hdl/mecanum_wheel_mixer.sv
// Top level of the mecanum wheel mixer: mix, scale and divider pipeline.
//
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ----------------------------------
// command   in         start && !busy       x_byte, y_byte, turn_byte
// result    out        done (one cycle)     {lf,lr,rf,rr}_forward, _speed
//
// One command per cycle; busy is never raised. Results leave in order
// through the mix stage, the numerator stage, one restoring-divider
// stage per quotient bit (7) and the output register. Reset clears all
// valid bits; payload is not reset.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
module mecanum_wheel_mixer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mwm_pkg::CMD_W-1:0]   x_byte,
    input  logic [mwm_pkg::CMD_W-1:0]   y_byte,
    input  logic [mwm_pkg::CMD_W-1:0]   turn_byte,
    output logic                        done,
    output logic                        lf_forward,
    output logic [mwm_pkg::SPEED_W-1:0] lf_speed,
    output logic                        lr_forward,
    output logic [mwm_pkg::SPEED_W-1:0] lr_speed,
    output logic                        rf_forward,
    output logic [mwm_pkg::SPEED_W-1:0] rf_speed,
    output logic                        rr_forward,
    output logic [mwm_pkg::SPEED_W-1:0] rr_speed
);
    import mwm_pkg::*;

    // ---------------------------------------------------------------
    // Stage 1: center commands, sum of magnitudes, four wheel mixes
    // ---------------------------------------------------------------
    logic signed [CMD_W-1:0] x_c, y_c, w_c;
    logic        [ABS_W-1:0] x_abs, y_abs, w_abs;
    logic signed [MIX_W-1:0] x_e, y_e, w_e;
    logic signed [MIX_W-1:0] mix_next [N_WHEEL];
    logic        [SUM_W-1:0] sum_next;

    logic                    mix_vld_reg;
    logic signed [MIX_W-1:0] mix_reg [N_WHEEL];
    logic        [SUM_W-1:0] sum_reg;

    always_comb
    begin
        // offset binary minus 128 is the MSB flipped
        x_c = signed'(x_byte ^ 8'h80);
        y_c = signed'(y_byte ^ 8'h80);
        w_c = signed'(turn_byte ^ 8'h80);
        x_e = MIX_W'(x_c);
        y_e = MIX_W'(y_c);
        w_e = MIX_W'(w_c);
        x_abs = x_e[MIX_W-1] ? ABS_W'(-x_e) : ABS_W'(x_e);
        y_abs = y_e[MIX_W-1] ? ABS_W'(-y_e) : ABS_W'(y_e);
        w_abs = w_e[MIX_W-1] ? ABS_W'(-w_e) : ABS_W'(w_e);
        sum_next = SUM_W'(x_abs) + SUM_W'(y_abs) + SUM_W'(w_abs);
        mix_next[WHEEL_LF] = x_e - y_e + w_e;
        mix_next[WHEEL_LR] = x_e + y_e + w_e;
        mix_next[WHEEL_RF] = x_e + y_e - w_e;
        mix_next[WHEEL_RR] = x_e - y_e - w_e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_vld_reg <= 1'b0;
        end
        else
        begin
            mix_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg <= mix_next;
        sum_reg <= sum_next;
    end

    // ---------------------------------------------------------------
    // Stage 2: numerator 100*|mix| and divisor max(s, 100).
    // With divisor 100 the quotient is |mix| itself, which covers both
    // the unscaled range and the all-centered case.
    // ---------------------------------------------------------------
    logic [SUM_W-1:0] dvs_next;
    lane_t            lane_next [N_WHEEL];
    logic [MAG_W-1:0] mag [N_WHEEL];

    always_comb
    begin
        dvs_next = (sum_reg > SUM_W'(SPEED_LIMIT)) ? sum_reg : SUM_W'(SPEED_LIMIT);
        for (int i = 0; i < N_WHEEL; i++)
        begin
            mag[i] = mix_reg[i][MIX_W-1] ? MAG_W'(-mix_reg[i]) : MAG_W'(mix_reg[i]);
            lane_next[i].neg = mix_reg[i][MIX_W-1];
            lane_next[i].rem = NUM_W'(mag[i]) * NUM_W'(SPEED_LIMIT);
            lane_next[i].quo = '0;
        end
    end

    // Divider pipeline registers; index 0 is the numerator stage
    logic             div_vld_reg [DIV_STEPS+1];
    logic [SUM_W-1:0] div_dvs_reg [DIV_STEPS+1];
    lane_t            div_lane_reg [DIV_STEPS+1][N_WHEEL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg[0] <= 1'b0;
        end
        else
        begin
            div_vld_reg[0] <= mix_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        div_dvs_reg[0]  <= dvs_next;
        div_lane_reg[0] <= lane_next;
    end

    // ---------------------------------------------------------------
    // Stages 3..9: restoring division, one quotient bit per stage,
    // most significant first. 100*|mix| < 128*divisor always holds.
    // ---------------------------------------------------------------
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        localparam int unsigned BIT = DIV_STEPS - 1 - k;

        logic [NUM_W-1:0] dvs_sh;
        logic [NUM_W:0]   trial [N_WHEEL];
        lane_t            step_next [N_WHEEL];

        always_comb
        begin
            dvs_sh = NUM_W'(div_dvs_reg[k]) << BIT;
            for (int i = 0; i < N_WHEEL; i++)
            begin
                trial[i] = {1'b0, div_lane_reg[k][i].rem} - {1'b0, dvs_sh};
                step_next[i] = div_lane_reg[k][i];
                if (!trial[i][NUM_W])
                begin
                    step_next[i].rem      = trial[i][NUM_W-1:0];
                    step_next[i].quo[BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                div_vld_reg[k+1] <= div_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            div_dvs_reg[k+1]  <= div_dvs_reg[k];
            div_lane_reg[k+1] <= step_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 10: output register; zero speed counts as forward
    // ---------------------------------------------------------------
    logic               done_reg;
    logic               fwd_next   [N_WHEEL];
    logic               fwd_reg    [N_WHEEL];
    logic [SPEED_W-1:0] speed_reg  [N_WHEEL];

    always_comb
    begin
        for (int i = 0; i < N_WHEEL; i++)
        begin
            fwd_next[i] = !div_lane_reg[DIV_STEPS][i].neg ||
                          (div_lane_reg[DIV_STEPS][i].quo == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N_WHEEL; i++)
        begin
            fwd_reg[i]   <= fwd_next[i];
            speed_reg[i] <= div_lane_reg[DIV_STEPS][i].quo;
        end
    end

    // Ports
    assign busy       = 1'b0;
    assign done       = done_reg;
    assign lf_forward = fwd_reg[WHEEL_LF];
    assign lf_speed   = speed_reg[WHEEL_LF];
    assign lr_forward = fwd_reg[WHEEL_LR];
    assign lr_speed   = speed_reg[WHEEL_LR];
    assign rf_forward = fwd_reg[WHEEL_RF];
    assign rf_speed   = speed_reg[WHEEL_RF];
    assign rr_forward = fwd_reg[WHEEL_RR];
    assign rr_speed   = speed_reg[WHEEL_RR];

endmodule

### hdl/mwm_checker.sv
// Port-level assertions for the mecanum wheel mixer, bound to the top level.
`timescale 1ns / 1ps
module mwm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [mwm_pkg::CMD_W-1:0]   x_byte,
    input logic [mwm_pkg::CMD_W-1:0]   y_byte,
    input logic [mwm_pkg::CMD_W-1:0]   turn_byte,
    input logic                        done,
    input logic                        lf_forward,
    input logic [mwm_pkg::SPEED_W-1:0] lf_speed,
    input logic                        lr_forward,
    input logic [mwm_pkg::SPEED_W-1:0] lr_speed,
    input logic                        rf_forward,
    input logic [mwm_pkg::SPEED_W-1:0] rf_speed,
    input logic                        rr_forward,
    input logic [mwm_pkg::SPEED_W-1:0] rr_speed
);
    import mwm_pkg::*;

    localparam int unsigned WARM_W = $clog2(LATENCY + 1);

    // Cycles since reset release, saturating at the pipeline latency
    logic [WARM_W-1:0] warm_reg;
    logic              warm;
    logic              accept;
    logic              centered;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
        end
        else if (warm_reg != WARM_W'(LATENCY))
        begin
            warm_reg <= warm_reg + 1'b1;
        end
    end

    assign warm     = (warm_reg == WARM_W'(LATENCY));
    assign accept   = start && !busy;
    assign centered = (x_byte == 8'h80) && (y_byte == 8'h80) && (turn_byte == 8'h80);

    // Every accepted transaction gives exactly one result
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        warm |-> (done == $past(accept, LATENCY)))
        else $error("result strobe does not match accepted transactions");

    // Magnitudes never exceed the speed limit
    a_speed_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (lf_speed <= SPEED_W'(SPEED_LIMIT)) && (lr_speed <= SPEED_W'(SPEED_LIMIT)) &&
                 (rf_speed <= SPEED_W'(SPEED_LIMIT)) && (rr_speed <= SPEED_W'(SPEED_LIMIT)))
        else $error("wheel speed above limit");

    // A stopped wheel reports forward
    a_zero_forward: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((lf_speed != '0) || lf_forward) && ((lr_speed != '0) || lr_forward) &&
                 ((rf_speed != '0) || rf_forward) && ((rr_speed != '0) || rr_forward))
        else $error("stopped wheel reports backward");

    // All commands centered gives all wheels stopped
    a_centered_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && $past(accept && centered, LATENCY)) |->
            (lf_speed == '0) && (lr_speed == '0) && (rf_speed == '0) && (rr_speed == '0))
        else $error("centered command does not stop all wheels");

endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (.*);

### tb/sv/tb.sv
// Self-checking testbench for the mecanum wheel mixer with an in-order scoreboard.
`timescale 1ns / 1ps
module tb;
    import mwm_pkg::*;

    localparam int unsigned RANDOM_CMDS = 1600;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          CENTER      = 128;

    // One wheel as the block reports it
    typedef struct packed {
        logic               fwd;
        logic [SPEED_W-1:0] spd;
    } wheel_t;

    typedef wheel_t [N_WHEEL-1:0] wheels_t;

    // Keeps the expected wheel sets in command order and checks each result
    class wheel_scoreboard;
        wheels_t pending_q[$];
        int      mismatches;
        int      commands_seen;
        int      results_seen;
        int      scaled_seen;
        int      stopped_seen;

        function new();
            mismatches    = 0;
            commands_seen = 0;
            results_seen  = 0;
            scaled_seen   = 0;
            stopped_seen  = 0;
        endfunction

        // Direction and magnitude of one wheel after the speed limit
        function wheel_t limit_wheel(int mix, int total);
            wheel_t w;
            int     mag;
            mag = (mix < 0) ? -mix : mix;
            if (total == 0)
                mag = 0;
            else if (total > SPEED_LIMIT)
                mag = (mag * SPEED_LIMIT) / total;
            if (mag > SPEED_LIMIT)
                mag = SPEED_LIMIT;
            w.fwd = (mix >= 0 || mag == 0) ? 1'b1 : 1'b0;
            w.spd = mag[SPEED_W-1:0];
            return w;
        endfunction

        // Inverse kinematics for one command
        function wheels_t mix_wheels(logic [CMD_W-1:0] xb, logic [CMD_W-1:0] yb,
                                     logic [CMD_W-1:0] wb);
            wheels_t ws;
            int      xs;
            int      ys;
            int      ws_rate;
            int      total;
            xs      = int'(xb) - CENTER;
            ys      = int'(yb) - CENTER;
            ws_rate = int'(wb) - CENTER;
            total   = ((xs < 0) ? -xs : xs) + ((ys < 0) ? -ys : ys)
                    + ((ws_rate < 0) ? -ws_rate : ws_rate);
            if (total > SPEED_LIMIT)
                scaled_seen++;
            if (total == 0)
                stopped_seen++;
            ws[WHEEL_LF] = limit_wheel(xs - ys + ws_rate, total);
            ws[WHEEL_LR] = limit_wheel(xs + ys + ws_rate, total);
            ws[WHEEL_RF] = limit_wheel(xs + ys - ws_rate, total);
            ws[WHEEL_RR] = limit_wheel(xs - ys - ws_rate, total);
            return ws;
        endfunction

        function void note_command(logic [CMD_W-1:0] xb, logic [CMD_W-1:0] yb,
                                   logic [CMD_W-1:0] wb);
            commands_seen++;
            pending_q.push_back(mix_wheels(xb, yb, wb));
        endfunction

        function void check_result(wheels_t got);
            wheels_t want;
            string   lane_name[N_WHEEL];
            lane_name[WHEEL_LF] = "lf";
            lane_name[WHEEL_LR] = "lr";
            lane_name[WHEEL_RF] = "rf";
            lane_name[WHEEL_RR] = "rr";
            results_seen++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, none pending: actual %h", $time, got);
                return;
            end
            want = pending_q.pop_front();
            for (int i = 0; i < N_WHEEL; i++)
            begin
                if (got[i].fwd !== want[i].fwd)
                begin
                    mismatches++;
                    $display("%0t: %s_forward mismatch: expected %0d actual %0d",
                             $time, lane_name[i], want[i].fwd, got[i].fwd);
                end
                if (got[i].spd !== want[i].spd)
                begin
                    mismatches++;
                    $display("%0t: %s_speed mismatch: expected %0d actual %0d",
                             $time, lane_name[i], want[i].spd, got[i].spd);
                end
            end
        endfunction

        function int pending_count();
            return pending_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   x_byte;
    logic [CMD_W-1:0]   y_byte;
    logic [CMD_W-1:0]   turn_byte;
    logic               done;
    logic               lf_forward;
    logic [SPEED_W-1:0] lf_speed;
    logic               lr_forward;
    logic [SPEED_W-1:0] lr_speed;
    logic               rf_forward;
    logic [SPEED_W-1:0] rf_speed;
    logic               rr_forward;
    logic [SPEED_W-1:0] rr_speed;

    wheel_scoreboard sb;
    wheels_t         observed;
    int unsigned     cycle_count;
    bit              no_idle;

    mecanum_wheel_mixer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_byte     (x_byte),
        .y_byte     (y_byte),
        .turn_byte  (turn_byte),
        .done       (done),
        .lf_forward (lf_forward),
        .lf_speed   (lf_speed),
        .lr_forward (lr_forward),
        .lr_speed   (lr_speed),
        .rf_forward (rf_forward),
        .rf_speed   (rf_speed),
        .rr_forward (rr_forward),
        .rr_speed   (rr_speed)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // Monitor: accepted commands and result strobes, sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(x_byte, y_byte, turn_byte);
            if (done)
            begin
                observed[WHEEL_LF] = {lf_forward, lf_speed};
                observed[WHEEL_LR] = {lr_forward, lr_speed};
                observed[WHEEL_RF] = {rf_forward, rf_speed};
                observed[WHEEL_RR] = {rr_forward, rr_speed};
                sb.check_result(observed);
            end
        end
    end

    // Idle cycles before the next command: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Command byte: corner values, near center, or anywhere
    function automatic logic [CMD_W-1:0] pick_byte(int unsigned kind);
        logic [CMD_W-1:0] corners[7];
        corners = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if (kind < 2)
            return corners[$urandom_range(0, 6)];
        else if (kind < 4)
            return CMD_W'($urandom_range(CENTER - 40, CENTER + 40));
        return CMD_W'($urandom_range(0, 255));
    endfunction

    // Present one command and hold it until the block takes it
    task automatic send_command(input logic [CMD_W-1:0] xb, input logic [CMD_W-1:0] yb,
                                input logic [CMD_W-1:0] wb);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        x_byte    <= xb;
        y_byte    <= yb;
        turn_byte <= wb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        logic [3*CMD_W-1:0] directed[17];
        int unsigned        kind;
        directed = '{
            {8'd128, 8'd128, 8'd128},   // all centered, zero sum
            {8'd0,   8'd0,   8'd0  },
            {8'd255, 8'd255, 8'd255},
            {8'd0,   8'd255, 8'd128},
            {8'd255, 8'd0,   8'd128},
            {8'd128, 8'd128, 8'd0  },
            {8'd128, 8'd128, 8'd255},
            {8'd228, 8'd128, 8'd128},   // sum exactly at the limit
            {8'd229, 8'd128, 8'd128},   // just over the limit
            {8'd127, 8'd128, 8'd128},   // small reverse, unscaled
            {8'd77,  8'd128, 8'd178},   // reverse mix truncated to zero
            {8'd0,   8'd128, 8'd128},
            {8'd128, 8'd0,   8'd0  },
            {8'd255, 8'd255, 8'd0  },
            {8'd1,   8'd254, 8'd129},
            {8'd170, 8'd86,  8'd200},
            {8'd128, 8'd129, 8'd127}
        };

        sb          = new();
        cycle_count = 0;
        no_idle     = 1'b0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        x_byte     <= '0;
        y_byte     <= '0;
        turn_byte  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands
        foreach (directed[i])
            send_command(directed[i][23:16], directed[i][15:8], directed[i][7:0]);

        // Random commands, in stretches with or without idle cycles chosen at random
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 200 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 9);
            send_command(pick_byte(kind), pick_byte(kind), pick_byte($urandom_range(0, 9)));
        end
        start <= 1'b0;

        // Drain the pipeline, then watch for stray strobes
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        $display("%0d commands sent, %0d results checked", sb.commands_seen,
                 sb.results_seen);
        $display("%0d commands over the speed limit, %0d fully centered",
                 sb.scaled_seen, sb.stopped_seen);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
